FILE: design/aksc_pkg.sv
// Shared types and constants for the Akima spline coefficient engine.
// Used by the front, the job queue, the arithmetic unit, the back and the top level.
package aksc_pkg;

	localparam int MIN_POINTS = 5;
	localparam int MAX_POINTS = 65535;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic JOB_POINT = 1'b0;
	localparam logic JOB_XERR  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FEW   = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;

	typedef struct packed {
		logic        kind;
		logic        last;
		logic [15:0] k;
		logic [31:0] x;
		logic [31:0] y;
	} aksc_job_t;

	typedef struct packed {
		logic [63:0] cubic;
		logic [63:0] quad;
		logic [63:0] slope;
		logic [31:0] value;
		logic [15:0] index;
		logic        last;
		logic [1:0]  status;
	} aksc_res_t;

	typedef struct packed {
		logic [2:0][63:0] a;
		logic [2:0][63:0] b;
		logic [63:0]      den;
	} aksc_mdu_cmd_t;

endpackage

FILE: design/aksc_front.sv
// Input front: accepts points, tracks set position and ordering, drops drained points.
// Pushes classified jobs into the job queue. Depends on aksc_pkg.
module aksc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       in_x,
	input  logic [31:0]       in_y,
	input  logic              in_last,
	input  logic              q_full,
	output logic              q_push,
	output aksc_pkg::aksc_job_t q_job
);
	import aksc_pkg::*;

	logic [15:0] count_q;
	logic        skip_q;
	logic [31:0] prev_x_q;
	logic        accept;
	logic        last_eff;
	logic        order_err;

	assign in_ready  = !q_full;
	assign accept    = in_valid && !q_full;
	assign last_eff  = in_last || (count_q >= 16'(MAX_POINTS - 1));
	assign order_err = (count_q != 16'd0) && (in_x <= prev_x_q);
	assign q_push    = accept && !skip_q;

	always_comb begin
		q_job.kind = order_err ? JOB_XERR : JOB_POINT;
		q_job.last = last_eff;
		q_job.k    = count_q;
		q_job.x    = in_x;
		q_job.y    = in_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			skip_q   <= 1'b0;
			prev_x_q <= '0;
		end else if (accept) begin
			if (skip_q) begin
				if (in_last)
					skip_q <= 1'b0;
			end else if (order_err) begin
				count_q <= '0;
				skip_q  <= !last_eff;
			end else begin
				prev_x_q <= in_x;
				count_q  <= last_eff ? 16'd0 : count_q + 16'd1;
			end
		end
	end

endmodule

FILE: design/aksc_queue.sv
// Short job queue between the input front and the computing back.
// Depends on aksc_pkg for the job type and depth.
module aksc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  aksc_pkg::aksc_job_t din,
	output logic              full,
	input  logic              pop,
	output aksc_pkg::aksc_job_t dout,
	output logic              empty
);
	import aksc_pkg::*;

	aksc_job_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;

	assign full  = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("job queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W + 1)'(QDEPTH))
		else $error("job queue count beyond depth");

endmodule

FILE: design/aksc_mdu.sv
// Shared multiply-accumulate and divide unit: sum of three signed 64x64 products over an
// unsigned 64-bit divisor, truncated and saturated to 64 bits. Depends on aksc_pkg.
module aksc_mdu (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  aksc_pkg::aksc_mdu_cmd_t cmd,
	output logic                   done,
	output logic [63:0]            res
);
	import aksc_pkg::*;

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_MUL  = 3'd1;
	localparam logic [2:0] M_NORM = 3'd2;
	localparam logic [2:0] M_DIV  = 3'd3;
	localparam logic [2:0] M_FIN  = 3'd4;

	localparam logic [2:0] STEP_LAST = 3'd5;
	localparam logic [1:0] TERM_LAST = 2'd2;
	localparam logic [6:0] DIV_LAST  = 7'd127;

	aksc_mdu_cmd_t cmd_q;
	logic [2:0]    mst_q;
	logic [1:0]    term_q;
	logic [2:0]    step_q;
	logic [63:0]   pp_q;
	logic [1:0]    psh_q;
	logic [127:0]  prod_q;
	logic [127:0]  acc_q;
	logic [127:0]  num_q;
	logic [63:0]   rem_q;
	logic [63:0]   quo_q;
	logic          ovf_q;
	logic          neg_q;
	logic [6:0]    cnt_q;
	logic          done_q;
	logic [63:0]   res_q;

	logic [63:0]   a_sel, b_sel, mag_a, mag_b;
	logic [31:0]   half_a, half_b;
	logic          sgn_w;
	logic [127:0]  pp_ext;
	logic [64:0]   r65, d65;
	logic          ge;
	logic          big;

	assign a_sel  = cmd_q.a[term_q];
	assign b_sel  = cmd_q.b[term_q];
	assign mag_a  = a_sel[63] ? 64'd0 - a_sel : a_sel;
	assign mag_b  = b_sel[63] ? 64'd0 - b_sel : b_sel;
	assign sgn_w  = a_sel[63] ^ b_sel[63];
	assign half_a = step_q[0] ? mag_a[63:32] : mag_a[31:0];
	assign half_b = step_q[1] ? mag_b[63:32] : mag_b[31:0];

	always_comb begin
		case (psh_q)
			2'd0:    pp_ext = {64'd0, pp_q};
			2'd1:    pp_ext = {32'd0, pp_q, 32'd0};
			default: pp_ext = {pp_q, 64'd0};
		endcase
	end

	assign r65 = {rem_q, num_q[127]};
	assign d65 = {1'b0, cmd_q.den};
	assign ge  = (r65 >= d65);
	assign big = ovf_q || quo_q[63];

	assign done = done_q;
	assign res  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mst_q  <= M_IDLE;
			term_q <= '0;
			step_q <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (mst_q)
				M_IDLE: begin
					if (go) begin
						term_q <= '0;
						step_q <= '0;
						mst_q  <= M_MUL;
					end
				end
				M_MUL: begin
					if (step_q == STEP_LAST) begin
						step_q <= '0;
						if (term_q == TERM_LAST)
							mst_q <= M_NORM;
						else
							term_q <= term_q + 2'd1;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				M_NORM: begin
					cnt_q <= '0;
					if (cmd_q.den == 64'd0) begin
						done_q <= 1'b1;
						mst_q  <= M_IDLE;
					end else begin
						mst_q <= M_DIV;
					end
				end
				M_DIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == DIV_LAST)
						mst_q <= M_FIN;
				end
				M_FIN: begin
					done_q <= 1'b1;
					mst_q  <= M_IDLE;
				end
				default: mst_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (mst_q)
			M_IDLE: begin
				if (go) begin
					cmd_q  <= cmd;
					acc_q  <= '0;
					prod_q <= '0;
				end
			end
			M_MUL: begin
				if (step_q <= 3'd3) begin
					pp_q  <= half_a * half_b;
					psh_q <= {1'b0, step_q[0]} + {1'b0, step_q[1]};
				end
				if (step_q >= 3'd1 && step_q <= 3'd4)
					prod_q <= prod_q + pp_ext;
				if (step_q == STEP_LAST) begin
					acc_q  <= acc_q + (prod_q ^ {128{sgn_w}}) + 128'(sgn_w);
					prod_q <= '0;
				end
			end
			M_NORM: begin
				neg_q <= acc_q[127];
				num_q <= acc_q[127] ? 128'd0 - acc_q : acc_q;
				rem_q <= '0;
				quo_q <= '0;
				ovf_q <= 1'b0;
				if (cmd_q.den == 64'd0)
					res_q <= '0;
			end
			M_DIV: begin
				rem_q <= ge ? 64'(r65 - d65) : r65[63:0];
				quo_q <= {quo_q[62:0], ge};
				ovf_q <= ovf_q | quo_q[63];
				num_q <= {num_q[126:0], 1'b0};
			end
			M_FIN: begin
				if (!neg_q)
					res_q <= big ? 64'h7FFF_FFFF_FFFF_FFFF : quo_q;
				else
					res_q <= big ? 64'h8000_0000_0000_0000 : 64'd0 - quo_q;
			end
			default: ;
		endcase
	end

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> (mst_q == M_IDLE))
		else $error("arithmetic unit started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("arithmetic unit done held for two cycles");

endmodule

FILE: design/aksc_back.sv
// Computing back: point windows, differences, Akima weights and derivatives, segment
// coefficients, result register. Depends on aksc_pkg and aksc_mdu.
module aksc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  aksc_pkg::aksc_job_t job,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output aksc_pkg::aksc_res_t out_res
);
	import aksc_pkg::*;

	localparam logic [3:0] B_IDLE = 4'd0;
	localparam logic [3:0] B_DIFF = 4'd1;
	localparam logic [3:0] B_WGT  = 4'd2;
	localparam logic [3:0] B_CHK  = 4'd3;
	localparam logic [3:0] B_TP0  = 4'd4;
	localparam logic [3:0] B_TP1  = 4'd5;
	localparam logic [3:0] B_AKI  = 4'd6;
	localparam logic [3:0] B_SEGC = 4'd7;
	localparam logic [3:0] B_SEGD = 4'd8;
	localparam logic [3:0] B_EMIT = 4'd9;
	localparam logic [3:0] B_TPL1 = 4'd10;
	localparam logic [3:0] B_TPL2 = 4'd11;

	localparam logic [1:0] SEG_MAIN = 2'd0;
	localparam logic [1:0] SEG_PRE  = 2'd1;
	localparam logic [1:0] SEG_END  = 2'd2;

	localparam logic [63:0] NEG_ONE = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_TWO = 64'hFFFF_FFFF_FFFF_FFFE;

	logic [3:0]        st_q;
	logic              issued_q;
	logic              last_q;
	logic [15:0]       k_q;
	logic [1:0]        seg_q;
	logic [4:0][31:0]  xw_q;
	logic [4:0][31:0]  yw_q;
	logic [3:0][63:0]  dw_q;
	logic [3:0][63:0]  ww_q;
	logic [1:0][63:0]  sw_q;
	logic [63:0]       t1_q, t2_q, c_q, wsq_q;
	aksc_res_t         res_q;
	aksc_res_t         out_q;
	logic              out_valid_q;

	aksc_mdu_cmd_t     cmd;
	logic              mdu_go, mdu_done;
	logic [63:0]       mdu_res;
	logic              arith, out_load;
	logic [32:0]       ydiff;
	logic [63:0]       h0, h1, dd, wabs;
	logic [1:0]        tp_mode;
	logic [31:0]       xa, xb, ya, wid;
	logic [63:0]       dj, bs0, bs1, wsq_w;
	logic [15:0]       sidx;

	function automatic aksc_res_t err_res(input logic [1:0] code);
		aksc_res_t r;
		r        = '0;
		r.last   = 1'b1;
		r.status = code;
		return r;
	endfunction

	aksc_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mdu_go),
		.cmd    (cmd),
		.done   (mdu_done),
		.res    (mdu_res)
	);

	assign arith = (st_q == B_DIFF) || (st_q == B_TP0) || (st_q == B_TP1) ||
		(st_q == B_AKI) || (st_q == B_SEGC) || (st_q == B_SEGD) ||
		(st_q == B_TPL1) || (st_q == B_TPL2);
	assign mdu_go   = arith && !issued_q;
	assign q_pop    = (st_q == B_IDLE) && !q_empty;
	assign out_load = (st_q == B_EMIT) && (!out_valid_q || out_ready);

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	assign ydiff = {yw_q[4][31], yw_q[4]} - {yw_q[3][31], yw_q[3]};
	assign h0    = {32'd0, xw_q[3] - xw_q[2]};
	assign h1    = {32'd0, xw_q[4] - xw_q[3]};
	assign dd    = dw_q[3] - dw_q[2];
	assign wabs  = dd[63] ? 64'd0 - dd : dd;

	always_comb begin
		case (seg_q)
			SEG_PRE: begin
				xa = xw_q[2]; xb = xw_q[3]; ya = yw_q[2]; dj = dw_q[2];
				bs0 = sw_q[1]; bs1 = t1_q; sidx = k_q - 16'd2;
			end
			SEG_END: begin
				xa = xw_q[3]; xb = xw_q[4]; ya = yw_q[3]; dj = dw_q[3];
				bs0 = t1_q; bs1 = t2_q; sidx = k_q - 16'd1;
			end
			default: begin
				xa = xw_q[1]; xb = xw_q[2]; ya = yw_q[1]; dj = dw_q[1];
				bs0 = sw_q[0]; bs1 = sw_q[1]; sidx = k_q - 16'd3;
			end
		endcase
	end

	assign wid   = xb - xa;
	assign wsq_w = {32'd0, wid} * {32'd0, wid};

	always_comb begin
		case (st_q)
			B_TP0:         tp_mode = 2'd0;
			B_TPL2:        tp_mode = 2'd2;
			default:       tp_mode = 2'd1;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (st_q)
			B_DIFF: begin
				cmd.a[0] = {{31{ydiff[32]}}, ydiff};
				cmd.b[0] = 64'd65536;
				cmd.den  = h1;
			end
			B_TP0, B_TP1, B_TPL1, B_TPL2: begin
				cmd.den = h0 + h1;
				case (tp_mode)
					2'd0: begin
						cmd.a[0] = (h0 << 1) + h1; cmd.b[0] = dw_q[2];
						cmd.a[1] = 64'd0 - h0;     cmd.b[1] = dw_q[3];
					end
					2'd2: begin
						cmd.a[0] = (h1 << 1) + h0; cmd.b[0] = dw_q[3];
						cmd.a[1] = 64'd0 - h1;     cmd.b[1] = dw_q[2];
					end
					default: begin
						cmd.a[0] = h1; cmd.b[0] = dw_q[2];
						cmd.a[1] = h0; cmd.b[1] = dw_q[3];
					end
				endcase
			end
			B_AKI: begin
				if (ww_q[3] == 64'd0 && ww_q[1] == 64'd0) begin
					cmd.a[0] = {32'd0, xw_q[3] - xw_q[2]}; cmd.b[0] = dw_q[1];
					cmd.a[1] = {32'd0, xw_q[2] - xw_q[1]}; cmd.b[1] = dw_q[2];
					cmd.den  = {32'd0, xw_q[3] - xw_q[2]} + {32'd0, xw_q[2] - xw_q[1]};
				end else begin
					cmd.a[0] = ww_q[3]; cmd.b[0] = dw_q[1];
					cmd.a[1] = ww_q[1]; cmd.b[1] = dw_q[2];
					cmd.den  = ww_q[3] + ww_q[1];
				end
			end
			B_SEGC: begin
				cmd.a[0] = dj;  cmd.b[0] = 64'd3;
				cmd.a[1] = bs0; cmd.b[1] = NEG_TWO;
				cmd.a[2] = bs1; cmd.b[2] = NEG_ONE;
				cmd.den  = {32'd0, wid};
			end
			B_SEGD: begin
				cmd.a[0] = bs0; cmd.b[0] = 64'd1;
				cmd.a[1] = bs1; cmd.b[1] = 64'd1;
				cmd.a[2] = dj;  cmd.b[2] = NEG_TWO;
				cmd.den  = wsq_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			k_q         <= '0;
			seg_q       <= SEG_MAIN;
			xw_q        <= '0;
			yw_q        <= '0;
			dw_q        <= '0;
			ww_q        <= '0;
			sw_q        <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (mdu_go)
				issued_q <= 1'b1;
			else if (mdu_done)
				issued_q <= 1'b0;
			unique case (st_q)
				B_IDLE: begin
					if (!q_empty) begin
						last_q <= job.last;
						k_q    <= job.k;
						if (job.kind == JOB_XERR) begin
							st_q <= B_EMIT;
						end else begin
							xw_q <= {job.x, xw_q[4:1]};
							yw_q <= {job.y, yw_q[4:1]};
							st_q <= (job.k != 16'd0) ? B_DIFF : B_CHK;
						end
					end
				end
				B_DIFF: begin
					if (mdu_done) begin
						dw_q <= {mdu_res, dw_q[3:1]};
						ww_q <= {64'd0, ww_q[3:1]};
						st_q <= B_WGT;
					end
				end
				B_WGT: begin
					if (k_q >= 16'd2)
						ww_q[3] <= wabs;
					st_q <= B_CHK;
				end
				B_CHK: begin
					seg_q <= SEG_MAIN;
					if (last_q && k_q < 16'(MIN_POINTS - 1))
						st_q <= B_EMIT;
					else if (k_q == 16'd2)
						st_q <= B_TP0;
					else if (k_q < 16'd3)
						st_q <= B_IDLE;
					else if (k_q >= 16'd4)
						st_q <= B_AKI;
					else
						st_q <= B_SEGC;
				end
				B_TP0: begin
					if (mdu_done) begin
						sw_q[0] <= mdu_res;
						st_q    <= B_TP1;
					end
				end
				B_TP1: begin
					if (mdu_done) begin
						sw_q[1] <= mdu_res;
						st_q    <= B_IDLE;
					end
				end
				B_AKI: begin
					if (mdu_done) begin
						sw_q <= {mdu_res, sw_q[1]};
						st_q <= B_SEGC;
					end
				end
				B_SEGC: begin
					if (mdu_done)
						st_q <= B_SEGD;
				end
				B_SEGD: begin
					if (mdu_done)
						st_q <= B_EMIT;
				end
				B_EMIT: begin
					if (out_load) begin
						if (res_q.status != ST_OK)
							st_q <= B_IDLE;
						else if (seg_q == SEG_MAIN)
							st_q <= last_q ? B_TPL1 : B_IDLE;
						else if (seg_q == SEG_PRE) begin
							seg_q <= SEG_END;
							st_q  <= B_SEGC;
						end else
							st_q <= B_IDLE;
					end
				end
				B_TPL1: begin
					if (mdu_done)
						st_q <= B_TPL2;
				end
				B_TPL2: begin
					if (mdu_done) begin
						seg_q <= SEG_PRE;
						st_q  <= B_SEGC;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= res_q;
		if (st_q == B_SEGC && mdu_go)
			wsq_q <= wsq_w;
		if (st_q == B_SEGC && mdu_done)
			c_q <= mdu_res;
		if (st_q == B_TPL1 && mdu_done)
			t1_q <= mdu_res;
		if (st_q == B_TPL2 && mdu_done)
			t2_q <= mdu_res;
		if (st_q == B_IDLE && !q_empty && job.kind == JOB_XERR)
			res_q <= err_res(ST_ORDER);
		if (st_q == B_CHK && last_q && k_q < 16'(MIN_POINTS - 1))
			res_q <= err_res(ST_FEW);
		if (st_q == B_SEGD && mdu_done) begin
			res_q.index  <= sidx;
			res_q.value  <= ya;
			res_q.slope  <= bs0;
			res_q.quad   <= c_q;
			res_q.cubic  <= mdu_res;
			res_q.last   <= (seg_q == SEG_END);
			res_q.status <= ST_OK;
		end
	end

	a_done_when_issued: assert property (@(posedge clk) disable iff (!arst_n)
		mdu_done |-> (arith && issued_q))
		else $error("arithmetic result arrived outside an issued step");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (st_q != B_IDLE))
		else $error("job taken without leaving idle");

endmodule

FILE: design/akima_spline_coefficients.sv
// Akima spline coefficient engine, top level: input front, job queue, computing back.
// Each division in the shared unit forms three 64x64 products from 32x32 partials, then
// runs a radix-2 quotient loop over the 128-bit numerator, then hands the result off.
// Divisions per point: none for the first, 1 for the second, 3 each at the third and fourth
// points, 4 for later points; a last point adds 6 more for the closing segments.
// The back works on one point at a time while the job queue holds later ones. Reset arst_n
// is asynchronous, active low: clears windows, counters and queue.
module akima_spline_coefficients (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,   // x_pos[31:0], y_val[63:32]
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [239:0] m_axis_tdata,   // seg_index, seg_value, slope, quad_coef, cubic_coef
	output logic         m_axis_tlast,
	output logic [1:0]   m_axis_tuser    // status
);
	import aksc_pkg::*;

	aksc_job_t push_job, pop_job;
	aksc_res_t res;
	logic      q_push, q_full, q_pop, q_empty;

	aksc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_x     (s_axis_tdata[31:0]),
		.in_y     (s_axis_tdata[63:32]),
		.in_last  (s_axis_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	aksc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (push_job),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (pop_job),
		.empty  (q_empty)
	);

	aksc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.job       (pop_job),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {res.cubic, res.quad, res.slope, res.value, res.index};
	assign m_axis_tlast = res.last;
	assign m_axis_tuser = res.status;

endmodule
